[hw/rtl/kfifo_pkg.sv]
// Shared types and constants for the key event FIFO.
`default_nettype none

package kfifo_pkg;

  localparam int CMD_W = 2;
  localparam int KEY_W = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 2'd0,
    CMD_CLICK = 2'd1,
    CMD_POP   = 2'd2
  } cmd_t;

  localparam logic [KEY_W-1:0] RELEASE_CODE = 8'h00;

endpackage

`default_nettype wire

[hw/rtl/kfifo_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module kfifo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/key_event_fifo.sv]
// Top level of the key event FIFO: pointer control around a single RAM.
//
// The block queues 8-bit key-state codes in a ring buffer that holds up to
// DEPTH-1 codes, one slot always being left empty so that full and empty differ.
// Each request on the input channel carries a command and a key byte: a push
// stores the key, a click stores the key followed by a zero release code as
// one pair (it needs two free slots), and a pop returns the oldest code.
// Every request yields exactly one result on the output channel: ok is set
// when the operation succeeded, and key_out carries the popped code on a
// successful pop and zero otherwise. Requests that do not fit, and pops on
// an empty queue, leave the queue untouched and report ok low.
// A push or a failed request presents its result in the cycle after it is
// accepted; a successful pop passes the registered RAM read data and then the
// output register. A successful click writes the key and then the release code
// through the single RAM write port and takes no request until both are done.
// Pushes and failed requests may arrive every cycle while out_stall is low.
// While the output register holds a result that the receiver stalls, no new
// request is taken. Reset sets both pointers to zero, which empties the
// queue at once; the RAM contents are not cleared and need no sweep.
`default_nettype none

module key_event_fifo #(
  parameter int DEPTH = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [kfifo_pkg::CMD_W-1:0] in_cmd,
  input  wire logic [kfifo_pkg::KEY_W-1:0] in_key_in,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_ok,
  output logic      [kfifo_pkg::KEY_W-1:0] out_key_out
);

  import kfifo_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

  // The sequencer is idle, writing the release code of a click, or waiting
  // for the RAM to return the code of a pop.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLICK2,
    ST_POPRD
  } state_t;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == LAST_SLOT) ? '0 : p + 1'b1;
  endfunction

  state_t           state_r, state_nxt;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_ok_r, out_ok_nxt;
  logic [KEY_W-1:0] out_key_r, out_key_nxt;

  logic             accept;
  logic [PTR_W-1:0] wr_n1, wr_n2, rd_n1;
  logic             ram_we, ram_re;
  logic [PTR_W-1:0] ram_waddr, ram_raddr;
  logic [KEY_W-1:0] ram_wdata, ram_rdata;

  // A request is taken only while idle and while the output register is
  // empty or is being emptied in this very cycle.
  assign in_stall = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;

  assign wr_n1 = ptr_next(wr_ptr_r);
  assign wr_n2 = ptr_next(wr_n1);
  assign rd_n1 = ptr_next(rd_ptr_r);

  always_comb begin
    state_nxt     = state_r;
    wr_ptr_nxt    = wr_ptr_r;
    rd_ptr_nxt    = rd_ptr_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_ok_nxt    = out_ok_r;
    out_key_nxt   = out_key_r;
    ram_we        = 1'b0;
    ram_waddr     = wr_n1;
    ram_wdata     = in_key_in;
    ram_re        = 1'b0;
    ram_raddr     = rd_n1;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          // Every outcome except a successful pop is known at once.
          out_valid_nxt = 1'b1;
          out_ok_nxt    = 1'b0;
          out_key_nxt   = '0;
          case (in_cmd)
            CMD_PUSH: begin
              if (wr_n1 != rd_ptr_r) begin
                ram_we     = 1'b1;
                wr_ptr_nxt = wr_n1;
                out_ok_nxt = 1'b1;
              end
            end
            CMD_CLICK: begin
              if ((wr_n1 != rd_ptr_r) && (wr_n2 != rd_ptr_r)) begin
                ram_we     = 1'b1;
                wr_ptr_nxt = wr_n2;
                out_ok_nxt = 1'b1;
                state_nxt  = ST_CLICK2;
              end
            end
            CMD_POP: begin
              if (wr_ptr_r != rd_ptr_r) begin
                ram_re        = 1'b1;
                rd_ptr_nxt    = rd_n1;
                out_valid_nxt = 1'b0;
                state_nxt     = ST_POPRD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_CLICK2: begin
        // The write pointer already names the release slot.
        ram_we    = 1'b1;
        ram_waddr = wr_ptr_r;
        ram_wdata = RELEASE_CODE;
        state_nxt = ST_IDLE;
      end
      ST_POPRD: begin
        out_valid_nxt = 1'b1;
        out_ok_nxt    = 1'b1;
        out_key_nxt   = ram_rdata;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_ok_r  <= out_ok_nxt;
    out_key_r <= out_key_nxt;
  end

  kfifo_ram #(
    .WIDTH(KEY_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign out_valid   = out_valid_r;
  assign out_ok      = out_ok_r;
  assign out_key_out = out_key_r;

  // The output register is always free when pop data comes back.
  a_poprd_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POPRD) |-> !out_valid_r)
    else $error("pop data returned while a result was still pending");

  // Pointers never leave the ring, also for depths that are not powers of two.
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r <= LAST_SLOT) && (rd_ptr_r <= LAST_SLOT))
    else $error("FIFO pointer out of range");

  // A pop on a non-empty queue always goes on to fetch its data.
  a_pop_issue: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_cmd == CMD_POP) && (wr_ptr_r != rd_ptr_r))
      |=> (state_r == ST_POPRD) && !out_valid_r)
    else $error("successful pop did not start a read");

  // The second half of a click writes the RAM and returns to idle in the next cycle.
  a_click2_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLICK2) |-> ram_we ##1 (state_r == ST_IDLE))
    else $error("release code write misbehaved");

  // A successful push or click never makes the queue look empty.
  a_not_empty_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && (state_r == ST_IDLE)) |=> (wr_ptr_r != rd_ptr_r))
    else $error("write left the queue empty");

endmodule

`default_nettype wire
